@@ rtl/core/lmds_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmds_pkg: shared definitions of the light map disc stamp
// Map geometry, field widths, command and register codes, and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package lmds_pkg;

    localparam int MAP_WIDTH  = 32;
    localparam int MAP_HEIGHT = 20;
    localparam int MAP_DEPTH  = MAP_WIDTH * MAP_HEIGHT;

    localparam int X_W    = $clog2(MAP_WIDTH);
    localparam int Y_W    = $clog2(MAP_HEIGHT);
    localparam int ADDR_W = $clog2(MAP_DEPTH);

    localparam int FUNC_W     = 2;
    localparam int POS_W      = 8;
    localparam int LEVEL_W    = 2;
    localparam int RAD_W      = 4;
    localparam int LIM_W      = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_LARGE = 2'd1,
        FUNC_SMALL = 2'd2,
        FUNC_READ  = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LARGE_RADIUS = 3'd0,
        CFG_LARGE_OUTER  = 3'd1,
        CFG_LARGE_INNER  = 3'd2,
        CFG_SMALL_RADIUS = 3'd3,
        CFG_SMALL_OUTER  = 3'd4,
        CFG_SMALL_INNER  = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_SWEEP,
        ST_RD_ADDR,
        ST_RD_DATA
    } state_t;

    typedef struct packed {
        logic load;       // capture the accepted request
        logic setup;      // work out the clipped stamp window
        logic sweep;      // visit one stamp cell
        logic clear_run;  // write level zero to one cell
        logic out_load;   // load the result register
    } lmds_cmd_t;

    typedef struct packed {
        logic empty;       // clipped window holds no cell
        logic sweep_last;  // current cell is the last of the window
        logic clear_last;  // current clear address is the last cell
        logic out_free;    // result register can take a new value
    } lmds_status_t;

endpackage

@@ rtl/core/light_map_disc_stamp_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_map_disc_stamp_top: light map with disc stamping
// Top level joining the sequencer and the datapath of the light map.
// ----------------------------------------------------------------------------
// The block holds a 32 x 20 map of light levels 0 to 2 in a single-port-write,
// registered-read memory and takes one request at a time. A clear request
// writes level zero to every cell, one cell per cycle. A large or small stamp
// request first clips its square window to the map in a setup step and then
// spends one cycle per visited cell, since each cell is a read-modify-write
// through the one memory read and write port, overlapped so that the read of
// the next cell runs alongside the write of the last. At radius 15 the map
// height limits the window to 30 x 20 cells. A read request returns exactly
// one result, level zero for a cell off the map, and stalls while the result
// register waits on m_ready. Clear and stamp requests return no result.
// Right after reset the block runs the same clearing pass with s_ready low;
// configuration writes are taken at any time but are meant to happen only
// while the block is idle.
// ----------------------------------------------------------------------------
module light_map_disc_stamp_top import lmds_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    // Configuration write port.
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    // Request channel.
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [FUNC_W-1:0]       s_func,
    input  logic signed [POS_W-1:0] s_pos_x,
    input  logic signed [POS_W-1:0] s_pos_y,
    // Result channel.
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [LEVEL_W-1:0]      m_light_level
);

    lmds_cmd_t    cmd;
    lmds_status_t status;

    // The sequencer owns the request handshake and steps the datapath.
    lmds_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_func),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath holds the map, the registers and the result register.
    lmds_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_func        (s_func),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_light_level (m_light_level),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

@@ rtl/core/lmds_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmds_ctrl: sequencer of the light map disc stamp
// Accepts one request at a time and steps the datapath through clearing,
// stamping or reading.
// ----------------------------------------------------------------------------
module lmds_ctrl import lmds_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [FUNC_W-1:0]   s_func,
    input  lmds_status_t        status,
    output lmds_cmd_t           cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_run = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    unique case (func_t'(s_func)) inside
                        FUNC_CLEAR:             state_next = ST_CLEAR;
                        FUNC_LARGE, FUNC_SMALL: state_next = ST_SETUP;
                        FUNC_READ:              state_next = ST_RD_ADDR;
                        default:                state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = status.empty ? ST_IDLE : ST_SWEEP;
            end
            ST_SWEEP: begin
                cmd.sweep = 1'b1;
                if (status.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD_ADDR: begin
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/lmds_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmds_dp: datapath of the light map disc stamp
// Configuration registers, the light map memory, window and level arithmetic
// of the stamp, the read-modify-write pipeline and the result register.
// ----------------------------------------------------------------------------
module lmds_dp import lmds_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic [FUNC_W-1:0]          s_func,
    input  logic signed [POS_W-1:0]    s_pos_x,
    input  logic signed [POS_W-1:0]    s_pos_y,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [LEVEL_W-1:0]         m_light_level,
    input  lmds_cmd_t                  cmd,
    output lmds_status_t               status
);

    localparam int DIFF_W = POS_W + 2;
    localparam int MAG_W  = RAD_W;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = SQ_W + 1;

    localparam logic signed [DIFF_W-1:0] W_S    = DIFF_W'(MAP_WIDTH);
    localparam logic signed [DIFF_W-1:0] H_S    = DIFF_W'(MAP_HEIGHT);
    localparam logic [ADDR_W-1:0]        W_A    = ADDR_W'(MAP_WIDTH);
    localparam logic [ADDR_W-1:0]        LAST_A = ADDR_W'(MAP_DEPTH - 1);

    // Magnitude of the offset from the centre, bumped by one at or beyond it.
    function automatic logic [MAG_W-1:0] bump_mag(input logic signed [DIFF_W-1:0] p,
                                                 input logic signed [DIFF_W-1:0] c);
        logic signed [DIFF_W-1:0] d;
        d = p - c;
        if (d >= 0) begin
            d = d + DIFF_W'(1);
        end else begin
            d = -d;
        end
        return d[MAG_W-1:0];
    endfunction

    // Configuration registers.
    logic [RAD_W-1:0] large_radius_reg, small_radius_reg;
    logic [LIM_W-1:0] large_outer_reg, large_inner_reg;
    logic [LIM_W-1:0] small_outer_reg, small_inner_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            large_radius_reg <= RAD_W'(7);
            large_outer_reg  <= LIM_W'(66);
            large_inner_reg  <= LIM_W'(46);
            small_radius_reg <= RAD_W'(5);
            small_outer_reg  <= LIM_W'(34);
            small_inner_reg  <= LIM_W'(24);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_LARGE_RADIUS: large_radius_reg <= cfg_data[RAD_W-1:0];
                CFG_LARGE_OUTER:  large_outer_reg  <= cfg_data[LIM_W-1:0];
                CFG_LARGE_INNER:  large_inner_reg  <= cfg_data[LIM_W-1:0];
                CFG_SMALL_RADIUS: small_radius_reg <= cfg_data[RAD_W-1:0];
                CFG_SMALL_OUTER:  small_outer_reg  <= cfg_data[LIM_W-1:0];
                CFG_SMALL_INNER:  small_inner_reg  <= cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Request capture and cell counters.
    logic signed [POS_W-1:0] cx_reg, cy_reg;
    logic                    large_reg;
    logic                    inmap_reg;
    logic [X_W-1:0]          x_reg, x_first_reg, x_last_reg;
    logic [Y_W-1:0]          y_reg, y_last_reg;

    // Window of the stamp, clipped to the map.
    logic [RAD_W-1:0]         radius;
    logic signed [DIFF_W-1:0] rad_s, cx_s, cy_s;
    logic signed [DIFF_W-1:0] x_lo, x_hi, y_lo, y_hi;
    logic signed [DIFF_W-1:0] x0c, x1c, y0c, y1c, x1m, y1m;

    always_comb begin
        radius = large_reg ? large_radius_reg : small_radius_reg;
        rad_s  = $signed(DIFF_W'(radius));
        cx_s   = DIFF_W'(cx_reg);
        cy_s   = DIFF_W'(cy_reg);
        x_lo   = cx_s - rad_s;
        x_hi   = cx_s + rad_s;
        y_lo   = cy_s - rad_s;
        y_hi   = cy_s + rad_s;
        x0c    = (x_lo < 0) ? '0 : x_lo;
        y0c    = (y_lo < 0) ? '0 : y_lo;
        x1c    = (x_hi > W_S) ? W_S : x_hi;
        y1c    = (y_hi > H_S) ? H_S : y_hi;
        x1m    = x1c - DIFF_W'(1);
        y1m    = y1c - DIFF_W'(1);
    end

    // Level of the current cell.
    logic [MAG_W-1:0]   mag_x, mag_y;
    logic [SQ_W-1:0]    sq_x, sq_y;
    logic [SUM_W-1:0]   sq_sum;
    logic [LIM_W-1:0]   outer_lim, inner_lim;
    logic [LEVEL_W-1:0] cell_level;
    logic [ADDR_W-1:0]  rd_addr;

    always_comb begin
        mag_x      = bump_mag($signed(DIFF_W'(x_reg)), cx_s);
        mag_y      = bump_mag($signed(DIFF_W'(y_reg)), cy_s);
        sq_x       = SQ_W'(mag_x) * SQ_W'(mag_x);
        sq_y       = SQ_W'(mag_y) * SQ_W'(mag_y);
        sq_sum     = SUM_W'(sq_x) + SUM_W'(sq_y);
        outer_lim  = large_reg ? large_outer_reg : small_outer_reg;
        inner_lim  = large_reg ? large_inner_reg : small_inner_reg;
        cell_level = LEVEL_W'(sq_sum <= SUM_W'(outer_lim))
                   + LEVEL_W'(sq_sum <= SUM_W'(inner_lim));
        rd_addr    = ADDR_W'(ADDR_W'(y_reg) * W_A) + ADDR_W'(x_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cx_reg    <= s_pos_x;
            cy_reg    <= s_pos_y;
            large_reg <= (func_t'(s_func) == FUNC_LARGE);
            x_reg     <= X_W'($unsigned(s_pos_x));
            y_reg     <= Y_W'($unsigned(s_pos_y));
            inmap_reg <= !s_pos_x[POS_W-1] && ($unsigned(s_pos_x) < POS_W'(MAP_WIDTH))
                      && !s_pos_y[POS_W-1] && ($unsigned(s_pos_y) < POS_W'(MAP_HEIGHT));
        end else if (cmd.setup) begin
            x_reg       <= x0c[X_W-1:0];
            y_reg       <= y0c[Y_W-1:0];
            x_first_reg <= x0c[X_W-1:0];
            x_last_reg  <= x1m[X_W-1:0];
            y_last_reg  <= y1m[Y_W-1:0];
        end else if (cmd.sweep) begin
            if (x_reg == x_last_reg) begin
                x_reg <= x_first_reg;
                y_reg <= y_reg + Y_W'(1);
            end else begin
                x_reg <= x_reg + X_W'(1);
            end
        end
    end

    // Light map memory: at most one write and one registered read each cycle.
    logic [LEVEL_W-1:0] map_mem [MAP_DEPTH];
    logic [LEVEL_W-1:0] rd_level_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [LEVEL_W-1:0] mem_wdata;

    // Write stage of the read-modify-write pipeline.
    logic               wr_valid_reg;
    logic [ADDR_W-1:0]  wr_addr_reg;
    logic [LEVEL_W-1:0] wr_level_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;

    always_comb begin
        if (cmd.clear_run) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = wr_valid_reg;
            mem_waddr = wr_addr_reg;
            mem_wdata = (rd_level_reg > wr_level_reg) ? rd_level_reg : wr_level_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        rd_level_reg <= map_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.sweep) begin
            wr_addr_reg  <= rd_addr;
            wr_level_reg <= cell_level;
        end
    end

    // Result register.
    logic               m_valid_reg, m_valid_next;
    logic [LEVEL_W-1:0] m_level_reg;

    assign m_valid_next = cmd.out_load ? 1'b1 : (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_valid_reg <= 1'b0;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            wr_valid_reg <= cmd.sweep;
            m_valid_reg  <= m_valid_next;
            if (cmd.clear_run) begin
                clr_addr_reg <= (clr_addr_reg == LAST_A) ? '0 : clr_addr_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_level_reg <= inmap_reg ? rd_level_reg : '0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_light_level = m_level_reg;

    assign status.empty      = (x0c >= x1c) || (y0c >= y1c);
    assign status.sweep_last = (x_reg == x_last_reg) && (y_reg == y_last_reg);
    assign status.clear_last = (clr_addr_reg == LAST_A);
    assign status.out_free   = !m_valid_reg || m_ready;

endmodule

@@ rtl/core/lmds_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmds_checker: port checks of the light map disc stamp
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module lmds_checker import lmds_pkg::*; (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic [FUNC_W-1:0]       s_func,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [LEVEL_W-1:0]      m_light_level
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_light_level))
        else $error("result changed while stalled");

    // Levels never exceed the brightest step.
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_light_level != 2'd3)
        else $error("light level out of range");

    // Only one request is in work at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while another was in work");

    // Clear and stamp requests never raise a result.
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_func != FUNC_READ) |=> !$rose(m_valid))
        else $error("result raised by a request that gives none");

endmodule

bind light_map_disc_stamp_top lmds_checker u_lmds_checker (.*);
